// ===== hdl/mtm_pkg.sv =====
// ----------------------------------------------------------------------------
// mtm_pkg
// Shared types and constants of the per-task message mailbox.
// ----------------------------------------------------------------------------
package mtm_pkg;

  // fixed field widths of the request and response channels
  localparam int unsigned ActionW = 2;
  localparam int unsigned TaskW   = 4;
  localparam int unsigned WordW   = 32;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned StatusW = 2;
  localparam int unsigned IdW     = 4;
  localparam int unsigned CountW  = 5;

  // configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned ActiveW  = 5;
  localparam int unsigned LiveW    = 16;

  localparam logic [CfgIdxW-1:0] CFG_ACTIVE_TASKS = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_LIVE_MASK    = 1'd1;

  typedef enum logic [ActionW-1:0] {
    ACT_SEND   = 2'd0,
    ACT_READ   = 2'd1,
    ACT_DELETE = 2'd2
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_TASK = 2'd1,
    ST_BAD_SLOT = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CNT,
    S_RD,
    S_SHIFT,
    S_DONE
  } mtm_state_e;

endpackage

// ===== hdl/mtm_if.sv =====
// ----------------------------------------------------------------------------
// mtm_if
// Request and response channel interfaces of the mailbox.
// ----------------------------------------------------------------------------
interface mtm_req_if import mtm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ActionW-1:0] action;
  logic [TaskW-1:0]   src_task;
  logic [TaskW-1:0]   to_task;
  logic [WordW-1:0]   payload;
  logic               msg_type;
  logic [SlotW-1:0]   slot;

  modport source (output valid, action, src_task, to_task, payload, msg_type, slot,
                  input ready);
  modport sink   (input valid, action, src_task, to_task, payload, msg_type, slot,
                  output ready);
endinterface

interface mtm_rsp_if import mtm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [TaskW-1:0]   sender;
  logic [WordW-1:0]   word;
  logic               kind;
  logic [IdW-1:0]     msg_id;
  logic [CountW-1:0]  count;

  modport source (output valid, status, sender, word, kind, msg_id, count,
                  input ready);
  modport sink   (input valid, status, sender, word, kind, msg_id, count,
                  output ready);
endinterface

// ===== hdl/mtm_store.sv =====
// ----------------------------------------------------------------------------
// mtm_store
// Message entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mtm_store #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8,
  parameter int unsigned DataW = 41
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/mtm_count.sv =====
// ----------------------------------------------------------------------------
// mtm_count
// Per-task message count memory; a valid bit per task makes unwritten
// counts read as zero after reset.
// ----------------------------------------------------------------------------
module mtm_count #(
  parameter int unsigned Tasks = 16,
  parameter int unsigned AddrW = 4,
  parameter int unsigned CntW  = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [CntW-1:0]  rdata_o,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [CntW-1:0]  wdata_i
);

  logic [CntW-1:0]  mem [Tasks];
  logic [Tasks-1:0] vld_q;
  logic [CntW-1:0]  rdata_q;
  logic             rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

// ===== hdl/per_task_message_mailbox_top.sv =====
// ----------------------------------------------------------------------------
// per_task_message_mailbox_top
// Inter-task mailbox engine: checked send, slot read, slot delete with
// compaction of the later entries.
// ----------------------------------------------------------------------------
// Usage:
//  - req_i carries one request (send, read slot, delete slot); it is taken
//    at a clock edge with valid and ready high. One request is in work at a
//    time: ready is high only while the engine is idle.
//  - rsp_o returns exactly one response per request through an output
//    register, so a new request can be taken while a response still waits.
//  - Configuration (active task count, live mask) must be written via
//    cfg_we_i/cfg_idx_i/cfg_data_i only while no request is in work; the
//    block does not enforce this. Accept to response valid: send passes
//    S_CNT, S_DONE; read S_CNT, S_RD, S_DONE; delete S_CNT, an S_SHIFT per
//    moved entry, S_DONE. The next request can be taken in the cycle the
//    response turns valid. Deletes are paced by the entry memory's single
//    read and write port: one entry moves per cycle. Every request reads
//    the count memory once (registered); reads also read the entry memory.
//  - Reset clears the configuration, the per-task count valid bits (all
//    mailboxes empty) and the control state; there is no clearing pass.
//  - If rsp_o stalls, the finished response holds in the output register
//    and the engine waits in its final state before taking the next one.
// ----------------------------------------------------------------------------
module per_task_message_mailbox_top import mtm_pkg::*; #(
  parameter int unsigned NUM_TASKS    = 16,
  parameter int unsigned MSG_SLOTS    = 16,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  mtm_req_if.sink             req_i,
  mtm_rsp_if.source           rsp_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // storage geometry
  localparam int unsigned TaskAW = $clog2(NUM_TASKS);
  localparam int unsigned SlotAW = (MSG_SLOTS > 1) ? $clog2(MSG_SLOTS) : 1;
  localparam int unsigned CntW   = $clog2(MSG_SLOTS + 1);
  localparam int unsigned StW    = (PAYLOAD_BITS < WordW) ? PAYLOAD_BITS : WordW;
  localparam int unsigned EntW   = TaskW + StW + 1 + IdW;
  localparam int unsigned AddrW  = TaskAW + SlotAW;
  localparam int unsigned Depth  = NUM_TASKS * (2 ** SlotAW);
  // widths for zero-extension before truncation to an index
  localparam int unsigned TaskXW = (TaskAW > TaskW) ? TaskAW : TaskW;
  localparam int unsigned SlotXW = (SlotAW > SlotW) ? SlotAW : SlotW;
  localparam int unsigned CmpW   = (CntW > SlotW) ? CntW : SlotW;

  // configuration registers
  logic [ActiveW-1:0] act_q;
  logic [LiveW-1:0]   live_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= '0;
      live_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ACTIVE_TASKS: act_q  <= cfg_data_i[ActiveW-1:0];
        CFG_LIVE_MASK:    live_q <= cfg_data_i[LiveW-1:0];
        default: ;
      endcase
    end
  end

  // request capture
  mtm_state_e state_q, state_d;
  logic       req_fire;

  logic [ActionW-1:0] req_act_q;
  logic [TaskW-1:0]   req_from_q;
  logic [TaskW-1:0]   req_to_q;
  logic [StW-1:0]     req_pay_q;
  logic               req_type_q;
  logic [SlotW-1:0]   req_slot_q;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      req_act_q  <= req_i.action;
      req_from_q <= req_i.src_task;
      req_to_q   <= req_i.to_task;
      req_pay_q  <= req_i.payload[StW-1:0];
      req_type_q <= req_i.msg_type;
      req_slot_q <= req_i.slot;
    end
  end

  logic [TaskXW-1:0] in_to_x, to_x;
  logic [TaskAW-1:0] in_task, task_idx;
  logic [SlotXW-1:0] slot_x;
  logic [SlotAW-1:0] slot_idx;

  assign in_to_x  = TaskXW'(req_i.to_task);
  assign in_task  = in_to_x[TaskAW-1:0];
  assign to_x     = TaskXW'(req_to_q);
  assign task_idx = to_x[TaskAW-1:0];
  assign slot_x   = SlotXW'(req_slot_q);
  assign slot_idx = slot_x[SlotAW-1:0];

  // memories
  logic            cnt_we;
  logic [CntW-1:0] cnt_wd, cnt_rd;

  mtm_count #(
    .Tasks (NUM_TASKS),
    .AddrW (TaskAW),
    .CntW  (CntW)
  ) u_count (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (req_fire),
    .raddr_i (in_task),
    .rdata_o (cnt_rd),
    .we_i    (cnt_we),
    .waddr_i (task_idx),
    .wdata_i (cnt_wd)
  );

  logic             st_we, st_re;
  logic [AddrW-1:0] st_wa, st_ra;
  logic [EntW-1:0]  st_wd, st_rd;

  mtm_store #(
    .Depth (Depth),
    .AddrW (AddrW),
    .DataW (EntW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_wa),
    .wdata_i (st_wd),
    .re_i    (st_re),
    .raddr_i (st_ra),
    .rdata_o (st_rd)
  );

  // checks on the captured request and the count just read
  logic from_ok, to_ok, to_real, send_ok, full, slot_ok, shift_first, shift_more;
  logic [CntW-1:0] cnt_q, cnt_d, shf_q, shf_d, slot_c;
  // slot fetched next: slot+1 when a delete starts, shf+2 while shifting
  logic [CntW-1:0] rd_slot1, rd_slot2;

  assign slot_c      = CntW'(req_slot_q);
  assign rd_slot1    = slot_c + CntW'(1);
  assign rd_slot2    = shf_q + CntW'(2);
  // usable tasks are below min(active_tasks, NUM_TASKS)
  assign from_ok     = (32'(req_from_q) < 32'(act_q)) && (32'(req_from_q) < NUM_TASKS);
  assign to_ok       = (32'(req_to_q) < 32'(act_q)) && (32'(req_to_q) < NUM_TASKS);
  assign to_real     = 32'(req_to_q) < NUM_TASKS;
  assign send_ok     = from_ok && to_ok && (req_from_q != req_to_q) &&
                       live_q[req_from_q] && live_q[req_to_q];
  assign full        = (cnt_rd == CntW'(MSG_SLOTS));
  assign slot_ok     = CmpW'(req_slot_q) < CmpW'(cnt_rd);
  assign shift_first = rd_slot1 < cnt_rd;
  assign shift_more  = rd_slot2 < cnt_q;

  // response staging and output register
  status_e          res_status_q, res_status_d;
  logic [TaskW-1:0] res_sender_q, res_sender_d;
  logic [StW-1:0]   res_word_q, res_word_d;
  logic             res_kind_q, res_kind_d;
  logic [IdW-1:0]   res_id_q, res_id_d;
  logic [CountW-1:0] res_cnt_q, res_cnt_d;

  logic out_free, rsp_vld_q;
  assign out_free = !rsp_vld_q || rsp_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_fire) state_d = S_CNT;
      end
      S_CNT: begin
        state_d = S_DONE;
        if (req_act_q == ACT_READ && to_ok && slot_ok) begin
          state_d = S_RD;
        end else if (req_act_q == ACT_DELETE && to_ok && slot_ok && shift_first) begin
          state_d = S_SHIFT;
        end
      end
      S_RD: state_d = S_DONE;
      S_SHIFT: begin
        if (!shift_more) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cnt_we       = 1'b0;
    cnt_wd       = cnt_rd;
    st_we        = 1'b0;
    st_wa        = {task_idx, shf_q[SlotAW-1:0]};
    st_wd        = st_rd;
    st_re        = 1'b0;
    st_ra        = {task_idx, slot_idx};
    cnt_d        = cnt_q;
    shf_d        = shf_q;
    res_status_d = res_status_q;
    res_sender_d = res_sender_q;
    res_word_d   = res_word_q;
    res_kind_d   = res_kind_q;
    res_id_d     = res_id_q;
    res_cnt_d    = res_cnt_q;

    unique case (state_q)
      S_CNT: begin
        cnt_d        = cnt_rd;
        res_status_d = ST_BAD_TASK;
        res_sender_d = '0;
        res_word_d   = '0;
        res_kind_d   = 1'b0;
        res_id_d     = '0;
        res_cnt_d    = to_real ? CountW'(cnt_rd) : '0;
        unique case (req_act_q)
          ACT_SEND: begin
            if (send_ok) begin
              if (full) begin
                res_status_d = ST_FULL;
              end else begin
                // append at the current count, id = count at send time
                st_we        = 1'b1;
                st_wa        = {task_idx, cnt_rd[SlotAW-1:0]};
                st_wd        = {req_from_q, req_pay_q, req_type_q, IdW'(cnt_rd)};
                cnt_we       = 1'b1;
                cnt_wd       = cnt_rd + CntW'(1);
                res_status_d = ST_OK;
                res_id_d     = IdW'(cnt_rd);
                res_cnt_d    = CountW'(cnt_rd + CntW'(1));
              end
            end
          end
          ACT_READ: begin
            if (to_ok) begin
              if (!slot_ok) begin
                res_status_d = ST_BAD_SLOT;
              end else begin
                st_re = 1'b1;
              end
            end
          end
          ACT_DELETE: begin
            if (to_ok) begin
              if (!slot_ok) begin
                res_status_d = ST_BAD_SLOT;
              end else begin
                // count drops now; later entries move down in S_SHIFT
                cnt_we       = 1'b1;
                cnt_wd       = cnt_rd - CntW'(1);
                res_status_d = ST_OK;
                res_cnt_d    = CountW'(cnt_rd - CntW'(1));
                if (shift_first) begin
                  st_re = 1'b1;
                  st_ra = {task_idx, rd_slot1[SlotAW-1:0]};
                  shf_d = slot_c;
                end
              end
            end
          end
          default: ;
        endcase
      end
      S_RD: begin
        res_status_d = ST_OK;
        res_sender_d = st_rd[EntW-1 -: TaskW];
        res_word_d   = st_rd[IdW+1 +: StW];
        res_kind_d   = st_rd[IdW];
        res_id_d     = st_rd[IdW-1:0];
      end
      S_SHIFT: begin
        // entry shf+1 arrived: write it to shf, fetch shf+2
        st_we = 1'b1;
        shf_d = shf_q + CntW'(1);
        if (shift_more) begin
          st_re = 1'b1;
          st_ra = {task_idx, rd_slot2[SlotAW-1:0]};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE && out_free) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  logic [StatusW-1:0] out_status_q;
  logic [TaskW-1:0]   out_sender_q;
  logic [WordW-1:0]   out_word_q;
  logic               out_kind_q;
  logic [IdW-1:0]     out_id_q;
  logic [CountW-1:0]  out_cnt_q;

  always_ff @(posedge clk_i) begin
    cnt_q        <= cnt_d;
    shf_q        <= shf_d;
    res_status_q <= res_status_d;
    res_sender_q <= res_sender_d;
    res_word_q   <= res_word_d;
    res_kind_q   <= res_kind_d;
    res_id_q     <= res_id_d;
    res_cnt_q    <= res_cnt_d;
    if (state_q == S_DONE && out_free) begin
      out_status_q <= res_status_q;
      out_sender_q <= res_sender_q;
      out_word_q   <= WordW'(res_word_q);
      out_kind_q   <= res_kind_q;
      out_id_q     <= res_id_q;
      out_cnt_q    <= res_cnt_q;
    end
  end

  assign rsp_o.valid  = rsp_vld_q;
  assign rsp_o.status = out_status_q;
  assign rsp_o.sender = out_sender_q;
  assign rsp_o.word   = out_word_q;
  assign rsp_o.kind   = out_kind_q;
  assign rsp_o.msg_id = out_id_q;
  assign rsp_o.count  = out_cnt_q;

  // assertions
  a_fire_to_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> state_q == S_CNT)
    else $error("accepted request did not reach count stage");

  a_shift_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SHIFT |-> (shf_q + CntW'(1)) < cnt_q)
    else $error("shift pointer ran past mailbox count");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_vld_q && out_status_q == ST_FULL |-> out_cnt_q == CountW'(MSG_SLOTS))
    else $error("full status with a mailbox that is not full");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_vld_q && out_status_q != ST_OK |->
      out_word_q == '0 && out_sender_q == '0 && out_id_q == '0 && !out_kind_q)
    else $error("error response carries message fields");

endmodule
